// ===== rtl/stok_pkg.sv =====
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types and constants of the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

   localparam int KIND_BITS = 6;
   localparam int LEN_BITS  = 16;
   localparam int POS_BITS  = 16;
   localparam int START_BITS = 24;

   localparam logic [KIND_BITS-1:0] K_SEMI    = 6'd0;
   localparam logic [KIND_BITS-1:0] K_LPAREN  = 6'd1;
   localparam logic [KIND_BITS-1:0] K_RPAREN  = 6'd2;
   localparam logic [KIND_BITS-1:0] K_LBRACE  = 6'd3;
   localparam logic [KIND_BITS-1:0] K_RBRACE  = 6'd4;
   localparam logic [KIND_BITS-1:0] K_LBRACK  = 6'd5;
   localparam logic [KIND_BITS-1:0] K_RBRACK  = 6'd6;
   localparam logic [KIND_BITS-1:0] K_SCOPE   = 6'd7;
   localparam logic [KIND_BITS-1:0] K_ARROW   = 6'd8;
   localparam logic [KIND_BITS-1:0] K_LARROW  = 6'd9;
   localparam logic [KIND_BITS-1:0] K_LA_DIV  = 6'd10;
   localparam logic [KIND_BITS-1:0] K_LA_MUL  = 6'd11;
   localparam logic [KIND_BITS-1:0] K_LA_SUB  = 6'd12;
   localparam logic [KIND_BITS-1:0] K_LA_ADD  = 6'd13;
   localparam logic [KIND_BITS-1:0] K_LE      = 6'd14;
   localparam logic [KIND_BITS-1:0] K_GE      = 6'd15;
   localparam logic [KIND_BITS-1:0] K_ASSIGN  = 6'd16;
   localparam logic [KIND_BITS-1:0] K_LT      = 6'd17;
   localparam logic [KIND_BITS-1:0] K_GT      = 6'd18;
   localparam logic [KIND_BITS-1:0] K_PLUS    = 6'd19;
   localparam logic [KIND_BITS-1:0] K_MINUS   = 6'd20;
   localparam logic [KIND_BITS-1:0] K_STAR    = 6'd21;
   localparam logic [KIND_BITS-1:0] K_SLASH   = 6'd22;
   localparam logic [KIND_BITS-1:0] K_STRING  = 6'd23;
   localparam logic [KIND_BITS-1:0] K_NUMBER  = 6'd24;
   localparam logic [KIND_BITS-1:0] K_IDENT   = 6'd25;
   localparam logic [KIND_BITS-1:0] K_KW0     = 6'd26;
   localparam logic [KIND_BITS-1:0] K_END     = 6'd46;
   localparam logic [KIND_BITS-1:0] K_ERR_NL  = 6'd47;
   localparam logic [KIND_BITS-1:0] K_ERR_EOF = 6'd48;
   localparam logic [KIND_BITS-1:0] K_ERR_CHR = 6'd49;

   localparam int NUM_KW = 20;
   localparam int KW_MAX = 8;

   // keyword text, first character in the low byte
   localparam logic [KW_MAX*8-1:0] KW_TEXT [NUM_KW] = '{
      64'h0000_0000_0072_6176, // var
      64'h0000_0000_0074_6573, // set
      64'h0000_6e72_6574_7865, // extern
      64'h0000_6369_7461_7473, // static
      64'h0000_0000_0000_6669, // if
      64'h0000_0000_6573_6c65, // else
      64'h0000_0000_6669_6c65, // elif
      64'h0000_0000_0072_6f66, // for
      64'h6e6f_6974_636e_7566, // function
      64'h0000_6e72_7574_6572, // return
      64'h6575_6e69_746e_6f63, // continue
      64'h0000_006b_6165_7262, // break
      64'h0000_0000_656b_616d, // make
      64'h0000_0073_7361_6c63, // class
      64'h0000_7463_7572_7473, // struct
      64'h0000_0000_6d75_6e65, // enum
      64'h0065_6761_6b63_6170, // package
      64'h0000_0000_0065_7375, // use
      64'h0000_0073_6169_6c61, // alias
      64'h0000_0000_0066_6572  // ref
   };
   localparam logic [3:0] KW_LEN [NUM_KW] = '{
      4'd3, 4'd3, 4'd6, 4'd6, 4'd2, 4'd4, 4'd4, 4'd3, 4'd8, 4'd6,
      4'd8, 4'd5, 4'd4, 4'd5, 4'd6, 4'd4, 4'd7, 4'd3, 4'd5, 4'd3
   };

   // one token as it travels from front to back
   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [START_BITS-1:0] start;
      logic [LEN_BITS-1:0]   length;
      logic [POS_BITS-1:0]   line;
      logic [POS_BITS-1:0]   column;
      logic                  last;
   } token_type;

   localparam int TOKEN_BITS = $bits(token_type);

endpackage

// ===== rtl/stok_front.sv =====
// ----------------------------------------------------------------------------
// stok_front
// Lexer front end: takes one byte per cycle while step is high, keeps the
// lexing state and produces up to two tokens per byte. The word buffer is
// resolved against the keyword list at flush time.
// ----------------------------------------------------------------------------
module stok_front #(
   parameter int MAX_KEYWORD_LEN = 8,
   parameter int OFFSET_BITS     = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 end_of_data,
   input  logic [7:0]           char_byte,
   output logic [1:0]           tok_count,
   output stok_pkg::token_type  tok_a,
   output stok_pkg::token_type  tok_b
);
   import stok_pkg::*;

   typedef enum logic [10:0] {
      M_IDLE    = 11'b000_0000_0001,
      M_COMMENT = 11'b000_0000_0010,
      M_SLASH   = 11'b000_0000_0100,
      M_COLON   = 11'b000_0000_1000,
      M_MINUS   = 11'b000_0001_0000,
      M_LT      = 11'b000_0010_0000,
      M_LTMINUS = 11'b000_0100_0000,
      M_GT      = 11'b000_1000_0000,
      M_STRING  = 11'b001_0000_0000,
      M_WORD    = 11'b010_0000_0000,
      M_NUMBER  = 11'b100_0000_0000
   } mode_type;

   localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
   localparam int BUF_BITS = MAX_KEYWORD_LEN * 8;
   localparam int IDX_BITS = $clog2(MAX_KEYWORD_LEN);

   mode_type               mode_ff, mode_in;
   logic [BUF_BITS-1:0]    word_ff, word_in;
   logic [LEN_BITS-1:0]    run_ff, run_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [POS_BITS-1:0]    line_ff, line_in;
   logic [POS_BITS-1:0]    col_ff, col_in;

   logic [KIND_BITS-1:0]   word_kind;
   logic                   is_digit, is_starter, is_blank;
   logic [START_BITS-1:0]  start_sat;

   // keyword match on the buffered word
   always_comb begin
      word_kind = K_IDENT;
      if (run_ff <= LEN_BITS'(KW_MAX)) begin
         for (int i = NUM_KW - 1; i >= 0; i--) begin
            if (run_ff == LEN_BITS'(KW_LEN[i])
                && word_ff[KW_MAX*8-1:0] == KW_TEXT[i])
               word_kind = K_KW0 + KIND_BITS'(i);
         end
      end
   end

   assign is_digit   = char_byte >= 8'h30 && char_byte <= 8'h39;
   assign is_starter = (char_byte >= 8'h41 && char_byte <= 8'h5a)
                       || (char_byte >= 8'h61 && char_byte <= 8'h7a)
                       || char_byte == 8'h5f;
   assign is_blank   = char_byte == 8'h20 || char_byte == 8'h09
                       || char_byte == 8'h0a || char_byte == 8'h0d;

   function automatic logic [START_BITS-1:0] sat_start(input logic [OFFSET_BITS-1:0] v);
      if (OFFSET_BITS > START_BITS && (v >> START_BITS) != '0)
         sat_start = '1;
      else
         sat_start = START_BITS'(v);
   endfunction

   assign start_sat = sat_start(start_ff);

   // lexing step
   always_comb begin
      logic [OFFSET_BITS-1:0] o;
      logic [POS_BITS-1:0]    ln, cl;
      logic                   fresh;
      logic [KIND_BITS-1:0]   k3;
      logic                   has3;
      mode_in  = mode_ff;
      word_in  = word_ff;
      run_in   = run_ff;
      start_in = start_ff;
      o        = off_ff;
      ln       = line_ff;
      cl       = col_ff;
      fresh    = 1'b0;
      k3       = K_LA_DIV;
      has3     = 1'b0;
      tok_count = 2'd0;
      tok_a = '0;
      tok_b = '0;

      if (end_of_data) begin
         // pending token, then end token, then reset state
         unique case (mode_ff)
            M_SLASH:   begin tok_a = '{K_SLASH, start_sat, 16'd1, ln, cl, 1'b0}; tok_count = 2'd1; end
            M_COLON:   begin tok_a = '{K_ERR_CHR, start_sat, 16'd1, ln, cl, 1'b0}; tok_count = 2'd1; end
            M_MINUS:   begin tok_a = '{K_MINUS, start_sat, 16'd1, ln, cl, 1'b0}; tok_count = 2'd1; end
            M_LT:      begin tok_a = '{K_LT, start_sat, 16'd1, ln, cl, 1'b0}; tok_count = 2'd1; end
            M_LTMINUS: begin tok_a = '{K_LARROW, start_sat, 16'd2, ln, cl, 1'b0}; tok_count = 2'd1; end
            M_GT:      begin tok_a = '{K_GT, start_sat, 16'd1, ln, cl, 1'b0}; tok_count = 2'd1; end
            M_WORD:    begin tok_a = '{word_kind, start_sat, run_ff, ln, cl, 1'b0}; tok_count = 2'd1; end
            M_NUMBER:  begin tok_a = '{K_NUMBER, start_sat, run_ff, ln, cl, 1'b0}; tok_count = 2'd1; end
            M_STRING:  begin tok_a = '{K_ERR_EOF, start_sat, run_ff, ln, cl, 1'b0}; tok_count = 2'd1; end
            default: ;
         endcase
         if (tok_count == 2'd1) begin
            tok_b = '{K_END, sat_start(off_ff), 16'd0, ln, cl, 1'b1};
            tok_count = 2'd2;
         end else begin
            tok_a = '{K_END, sat_start(off_ff), 16'd0, ln, cl, 1'b1};
            tok_count = 2'd1;
         end
         mode_in = M_IDLE; word_in = '0; run_in = '0; start_in = '0;
         o = '0; ln = '0; cl = '0;
      end else begin
         unique case (mode_ff)
            M_IDLE: fresh = 1'b1;
            M_COMMENT: fresh = char_byte == 8'h0a;
            M_STRING: begin
               if (char_byte == 8'h22) begin
                  mode_in = M_IDLE;
                  tok_count = 2'd1;
                  tok_a = '{K_STRING, start_sat, run_ff, 16'd0, 16'd0, 1'b0};
               end else if (char_byte == 8'h0a) begin
                  tok_a = '{K_ERR_NL, start_sat, run_ff, ln, cl, 1'b0};
                  tok_count = 2'd1;
                  fresh = 1'b1;
               end else if (run_ff != '1) begin
                  run_in = run_ff + 1'b1;
               end
            end
            M_WORD, M_NUMBER: begin
               if (is_digit || (mode_ff == M_WORD && is_starter)) begin
                  if (run_ff < LEN_BITS'(MAX_KEYWORD_LEN))
                     word_in[8*run_ff[IDX_BITS-1:0] +: 8] = char_byte;
                  if (run_ff != '1) run_in = run_ff + 1'b1;
               end else begin
                  tok_a = '{(mode_ff == M_WORD) ? word_kind : K_NUMBER,
                            start_sat, run_ff, ln, cl, 1'b0};
                  tok_count = 2'd1;
                  fresh = 1'b1;
               end
            end
            M_SLASH: begin
               if (char_byte == 8'h2f) mode_in = M_COMMENT;
               else begin
                  tok_a = '{K_SLASH, start_sat, 16'd1, ln, cl, 1'b0};
                  tok_count = 2'd1; fresh = 1'b1;
               end
            end
            M_COLON: begin
               if (char_byte == 8'h3a) begin
                  mode_in = M_IDLE; tok_count = 2'd1;
                  tok_a = '{K_SCOPE, start_sat, 16'd2, 16'd0, 16'd0, 1'b0};
               end else begin
                  tok_a = '{K_ERR_CHR, start_sat, 16'd1, ln, cl, 1'b0};
                  tok_count = 2'd1; fresh = 1'b1;
               end
            end
            M_MINUS: begin
               if (char_byte == 8'h3e) begin
                  mode_in = M_IDLE; tok_count = 2'd1;
                  tok_a = '{K_ARROW, start_sat, 16'd2, 16'd0, 16'd0, 1'b0};
               end else begin
                  tok_a = '{K_MINUS, start_sat, 16'd1, ln, cl, 1'b0};
                  tok_count = 2'd1; fresh = 1'b1;
               end
            end
            M_GT: begin
               if (char_byte == 8'h3d) begin
                  mode_in = M_IDLE; tok_count = 2'd1;
                  tok_a = '{K_GE, start_sat, 16'd2, 16'd0, 16'd0, 1'b0};
               end else begin
                  tok_a = '{K_GT, start_sat, 16'd1, ln, cl, 1'b0};
                  tok_count = 2'd1; fresh = 1'b1;
               end
            end
            M_LT: begin
               if (char_byte == 8'h2d) mode_in = M_LTMINUS;
               else if (char_byte == 8'h3d) begin
                  mode_in = M_IDLE; tok_count = 2'd1;
                  tok_a = '{K_LE, start_sat, 16'd2, 16'd0, 16'd0, 1'b0};
               end else begin
                  tok_a = '{K_LT, start_sat, 16'd1, ln, cl, 1'b0};
                  tok_count = 2'd1; fresh = 1'b1;
               end
            end
            M_LTMINUS: begin
               case (char_byte)
                  8'h2f: begin k3 = K_LA_DIV; has3 = 1'b1; end
                  8'h2a: begin k3 = K_LA_MUL; has3 = 1'b1; end
                  8'h2d: begin k3 = K_LA_SUB; has3 = 1'b1; end
                  8'h2b: begin k3 = K_LA_ADD; has3 = 1'b1; end
                  default: ;
               endcase
               if (has3) begin
                  mode_in = M_IDLE; tok_count = 2'd1;
                  tok_a = '{k3, start_sat, 16'd3, 16'd0, 16'd0, 1'b0};
               end else begin
                  tok_a = '{K_LARROW, start_sat, 16'd2, ln, cl, 1'b0};
                  tok_count = 2'd1; fresh = 1'b1;
               end
            end
            default: fresh = 1'b1;
         endcase

         // lex the byte from idle; it may emit one token of its own
         if (fresh) begin
            logic [KIND_BITS-1:0] sk;
            logic                 simple;
            logic [START_BITS-1:0] here;
            sk = K_SEMI; simple = 1'b0;
            here = sat_start(off_ff);
            start_in = off_ff;
            mode_in = M_IDLE;
            case (char_byte)
               8'h3b: begin sk = K_SEMI;    simple = 1'b1; end
               8'h28: begin sk = K_LPAREN;  simple = 1'b1; end
               8'h29: begin sk = K_RPAREN;  simple = 1'b1; end
               8'h7b: begin sk = K_LBRACE;  simple = 1'b1; end
               8'h7d: begin sk = K_RBRACE;  simple = 1'b1; end
               8'h5b: begin sk = K_LBRACK;  simple = 1'b1; end
               8'h5d: begin sk = K_RBRACK;  simple = 1'b1; end
               8'h3d: begin sk = K_ASSIGN;  simple = 1'b1; end
               8'h2b: begin sk = K_PLUS;    simple = 1'b1; end
               8'h2a: begin sk = K_STAR;    simple = 1'b1; end
               8'h3a: mode_in = M_COLON;
               8'h2d: mode_in = M_MINUS;
               8'h3c: mode_in = M_LT;
               8'h3e: mode_in = M_GT;
               8'h2f: mode_in = M_SLASH;
               8'h22: begin
                  mode_in = M_STRING;
                  run_in = '0;
                  start_in = (off_ff == OFF_MAX) ? off_ff : off_ff + 1'b1;
               end
               default: begin
                  if (is_blank) ;
                  else if (is_starter || is_digit) begin
                     word_in = '0;
                     word_in[7:0] = char_byte;
                     run_in = LEN_BITS'(1);
                     mode_in = is_digit ? M_NUMBER : M_WORD;
                  end else begin
                     sk = K_ERR_CHR; simple = 1'b1;
                  end
               end
            endcase
            if (simple) begin
               // position after this byte: filled in below
               if (tok_count == 2'd1) begin
                  tok_b = '{sk, here, 16'd1, 16'd0, 16'd0, 1'b0};
                  tok_count = 2'd2;
               end else begin
                  tok_a = '{sk, here, 16'd1, 16'd0, 16'd0, 1'b0};
                  tok_count = 2'd1;
               end
            end
         end

         // advance position over the byte
         if (o != OFF_MAX) o = o + 1'b1;
         if (char_byte == 8'h0a) begin
            cl = '0;
            if (ln != '1) ln = ln + 1'b1;
         end else if (cl != '1) begin
            cl = cl + 1'b1;
         end

         // tokens completed by this byte carry the position after it
         if (fresh && tok_count == 2'd2) begin
            tok_b.line = ln; tok_b.column = cl;
         end else if (fresh && tok_count == 2'd1 && tok_a.line == 16'd0
                      && tok_a.column == 16'd0 && tok_a.kind != K_ERR_NL
                      && mode_ff != M_WORD && mode_ff != M_NUMBER
                      && mode_ff != M_SLASH && mode_ff != M_COLON
                      && mode_ff != M_MINUS && mode_ff != M_GT
                      && mode_ff != M_LT && mode_ff != M_LTMINUS) begin
            tok_a.line = ln; tok_a.column = cl;
         end else if (!fresh && tok_count == 2'd1) begin
            tok_a.line = ln; tok_a.column = cl;
         end
         if (tok_count == 2'd2) tok_b.last = 1'b1;
         else if (tok_count == 2'd1) tok_a.last = 1'b1;
      end
      off_in  = o;
      line_in = ln;
      col_in  = cl;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         word_ff  <= '0;
         run_ff   <= '0;
         start_ff <= '0;
         off_ff   <= '0;
         line_ff  <= '0;
         col_ff   <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         word_ff  <= word_in;
         run_ff   <= run_in;
         start_ff <= start_in;
         off_ff   <= off_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
      end
   end

endmodule

// ===== rtl/stok_queue.sv =====
// ----------------------------------------------------------------------------
// stok_queue
// Token queue between lexer and output: takes up to two tokens a cycle,
// hands out one while out_ready is high.
// ----------------------------------------------------------------------------
module stok_queue #(
   parameter int DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_count,
   input  stok_pkg::token_type  push_a,
   input  stok_pkg::token_type  push_b,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output stok_pkg::token_type  out_token
);
   import stok_pkg::*;

   localparam int PTR_BITS = $clog2(DEPTH);

   token_type             slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   rd_ff, wr_ff;
   logic [PTR_BITS:0]     fill_ff, fill_in;
   logic                  pop;
   logic [PTR_BITS-1:0]   wr_next;

   assign pop       = out_valid && out_ready;
   assign out_valid = fill_ff != '0;
   assign out_token = slot_ff[rd_ff];
   // room for two more tokens
   assign room      = fill_ff <= (PTR_BITS+1)'(DEPTH - 2);
   assign wr_next   = wr_ff + 1'b1;
   assign fill_in   = fill_ff + (PTR_BITS+1)'(push_count) - (PTR_BITS+1)'(pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) slot_ff[wr_ff] <= push_a;
      if (push_count == 2'd2) slot_ff[wr_next] <= push_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff   <= '0;
         wr_ff   <= '0;
         fill_ff <= '0;
      end else begin
         rd_ff   <= rd_ff + PTR_BITS'(pop);
         wr_ff   <= wr_ff + PTR_BITS'(push_count);
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== rtl/source_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one word per source byte; req_tuser high marks end of
//   data (req_tdata is then ignored). rsp_ channel: one word per token,
//   rsp_tlast high on the last token caused by one input word.
//   A byte is taken every cycle while the token queue has room for two
//   more tokens: sustained rate one byte per cycle. Each byte gives zero,
//   one or two tokens; a token enters the queue when the byte that
//   completes it is taken. Up to two tokens per byte are drained at one
//   per cycle while rsp_tready is high, so bursts longer than the queue
//   slow req_. When the receiver stalls, tokens collect in the queue and
//   req_tready falls once fewer than two slots are free. After end of
//   data the position counters return to zero. Reset (synchronous)
//   empties the queue and returns the lexer to idle at offset zero.
// ----------------------------------------------------------------------------
module source_tokenizer #(
   parameter int MAX_KEYWORD_LEN = 8,
   parameter int OFFSET_BITS     = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // char_byte
   input  logic         req_tuser,  // end_of_data
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata,  // token_kind, start_offset, token_length,
                                    // line_number, column_number, zero fill
   output logic         rsp_tlast   // last_of_run
);
   import stok_pkg::*;

   logic       step;
   logic [1:0] tok_count, push_count;
   token_type  tok_a, tok_b, q_tok;

   assign step       = req_tvalid && req_tready;
   assign push_count = step ? tok_count : 2'd0;

   stok_front #(
      .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN),
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock(clock), .reset(reset), .step(step),
      .end_of_data(req_tuser), .char_byte(req_tdata),
      .tok_count(tok_count), .tok_a(tok_a), .tok_b(tok_b)
   );

   stok_queue #(.DEPTH(8)) u_queue (
      .clock(clock), .reset(reset),
      .push_count(push_count), .push_a(tok_a), .push_b(tok_b),
      .room(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_token(q_tok)
   );

   assign rsp_tdata = {2'd0, q_tok.column, q_tok.line, q_tok.length,
                       q_tok.start, q_tok.kind};
   assign rsp_tlast = q_tok.last;

endmodule

// ===== rtl/stok_checker.sv =====
// ----------------------------------------------------------------------------
// stok_checker
// Port-level checks of the source tokenizer.
// ----------------------------------------------------------------------------
module stok_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tlast
);
   // stalled token holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast))
      else $error("token changed under stall");

   // end of data always yields a token next cycle
   a_end: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> rsp_tvalid)
      else $error("no token after end of data");

   // token kinds stay in range
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:0] <= 6'd49)
      else $error("token kind out of range");

   // no output straight out of reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("token after reset");
endmodule

bind source_tokenizer stok_checker u_stok_checker (.*);
